[design/isfr_pkg.sv]
// ----------------------------------------------------------------------------
// isfr_pkg
// Shared types and constants of the servo frame receiver: parser phases,
// sequencer states, frame constants and the job handed from front to back.
// ----------------------------------------------------------------------------
package isfr_pkg;

  // Parser phase of the front part
  typedef enum logic [2:0] {
    PH_LENGTH  = 3'd0,
    PH_DATA    = 3'd1,
    PH_SUM_LO  = 3'd2,
    PH_SUM_HI  = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  // Channel word sequencer of the back part
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_EMIT = 2'd2
  } back_state_t;

  // Frame constants
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd3;
  localparam logic [7:0]  SERVO_COMMAND  = 8'h40;
  localparam logic [15:0] SUM_INIT       = 16'hFFFF;
  localparam logic [7:0]  GAP_RESET      = 8'd3;

  // Field widths fixed by the result items
  localparam int CHAN_W = 4;
  localparam int POS_W  = 5;

  // Register index of the gap setting (address bit 2 upwards)
  localparam logic REG_GAP = 1'b0;

  // One checked servo frame waiting for the back part
  typedef struct packed {
    logic       valid;
    logic [7:0] frame_count;
  } job_t;

endpackage

[design/isfr_front.sv]
// ----------------------------------------------------------------------------
// isfr_front
// Byte parser: gap detection, length check, payload capture into the frame
// store, checksum accumulation and hand-over of good servo frames.
// ----------------------------------------------------------------------------
module isfr_front #(
  parameter int MAX_FRAME_BYTES = 32,
  parameter int PW              = 6,
  parameter int AW              = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          elapsed_ms,
  input  logic [7:0]          gap_ms,
  input  logic                back_busy,
  output isfr_pkg::job_t      job,
  input  logic                job_take,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data
);

  localparam logic [7:0]    MAX_B = 8'(MAX_FRAME_BYTES);
  localparam logic [PW-1:0] MAX_P = PW'(MAX_FRAME_BYTES);

  isfr_pkg::phase_t phase, phase_next, phase_eff;
  logic [PW-1:0]    store_pointer, store_pointer_next, ptr_inc;
  logic [PW-1:0]    payload_length, payload_length_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       sum_low_byte, sum_low_byte_next;
  logic [7:0]       cmd_byte, cmd_byte_next;
  logic [7:0]       servo_frames, servo_frames_next;
  isfr_pkg::job_t   job_next;
  logic             accept;

  // The store is shared with the back part, so no item enters while a frame
  // is pending or being sent out.
  assign full   = job.valid || back_busy;
  assign accept = push && !full;

  // A long enough silence forces the length phase before the byte is parsed
  assign phase_eff = (elapsed_ms >= gap_ms) ? isfr_pkg::PH_LENGTH : phase;
  assign ptr_inc   = store_pointer + PW'(1);

  // Store write port
  assign wr_en   = accept && (phase_eff == isfr_pkg::PH_DATA) && (store_pointer < MAX_P);
  assign wr_addr = AW'(store_pointer);
  assign wr_data = data_byte;

  // Parser next state
  always_comb begin
    phase_next          = phase;
    store_pointer_next  = store_pointer;
    payload_length_next = payload_length;
    running_sum_next    = running_sum;
    sum_low_byte_next   = sum_low_byte;
    cmd_byte_next       = cmd_byte;
    servo_frames_next   = servo_frames;
    job_next            = job;
    if (job_take) begin
      job_next.valid = 1'b0;
    end
    if (accept) begin
      case (phase_eff)
        isfr_pkg::PH_LENGTH: begin
          if ((data_byte <= MAX_B) && (data_byte > isfr_pkg::FRAME_OVERHEAD)) begin
            store_pointer_next  = '0;
            payload_length_next = PW'(data_byte - isfr_pkg::FRAME_OVERHEAD);
            running_sum_next    = isfr_pkg::SUM_INIT - {8'd0, data_byte};
            phase_next          = isfr_pkg::PH_DATA;
          end else begin
            phase_next = isfr_pkg::PH_DISCARD;
          end
        end
        isfr_pkg::PH_DATA: begin
          if (store_pointer == '0) begin
            cmd_byte_next = data_byte;
          end
          store_pointer_next = ptr_inc;
          running_sum_next   = running_sum - {8'd0, data_byte};
          if (ptr_inc >= payload_length) begin
            phase_next = isfr_pkg::PH_SUM_LO;
          end
        end
        isfr_pkg::PH_SUM_LO: begin
          sum_low_byte_next = data_byte;
          phase_next        = isfr_pkg::PH_SUM_HI;
        end
        isfr_pkg::PH_SUM_HI: begin
          if (({data_byte, sum_low_byte} == running_sum) &&
              (cmd_byte == isfr_pkg::SERVO_COMMAND)) begin
            servo_frames_next    = servo_frames + 8'd1;
            job_next.valid       = 1'b1;
            job_next.frame_count = servo_frames + 8'd1;
          end
          phase_next = isfr_pkg::PH_DISCARD;
        end
        default: begin
          phase_next = isfr_pkg::PH_DISCARD;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= isfr_pkg::PH_LENGTH;
      cmd_byte     <= 8'd0;
      servo_frames <= 8'd0;
      job          <= '0;
    end else begin
      phase        <= phase_next;
      cmd_byte     <= cmd_byte_next;
      servo_frames <= servo_frames_next;
      job          <= job_next;
    end
  end

  // Frame payload registers
  always_ff @(posedge clk) begin
    store_pointer  <= store_pointer_next;
    payload_length <= payload_length_next;
    running_sum    <= running_sum_next;
    sum_low_byte   <= sum_low_byte_next;
  end

endmodule

[design/isfr_back.sv]
// ----------------------------------------------------------------------------
// isfr_back
// Frame store and channel word sequencer: reads two store bytes per channel
// and presents each channel word in an output register.
// ----------------------------------------------------------------------------
module isfr_back #(
  parameter int MAX_FRAME_BYTES = 32,
  parameter int CHANNEL_COUNT   = 14,
  parameter int AW              = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  isfr_pkg::job_t                job,
  output logic                          job_take,
  output logic                          busy,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [7:0]                    wr_data,
  output logic                          empty,
  input  logic                          pop,
  output logic [isfr_pkg::CHAN_W-1:0]   channel_index,
  output logic [15:0]                   channel_value,
  output logic [7:0]                    frame_count,
  output logic                          last_channel
);

  localparam logic [7:0] MAX_B = 8'(MAX_FRAME_BYTES);
  localparam logic [isfr_pkg::CHAN_W-1:0] LAST_CH = isfr_pkg::CHAN_W'(CHANNEL_COUNT - 1);

  logic [7:0]                  mem [MAX_FRAME_BYTES];
  logic [MAX_FRAME_BYTES-1:0]  store_vld;

  isfr_pkg::back_state_t       state, state_next;
  logic [isfr_pkg::CHAN_W-1:0] ch, ch_next;
  logic [7:0]                  job_count, job_count_next;
  logic [isfr_pkg::POS_W-1:0]  lo_pos, hi_pos;
  logic                        lo_in, hi_in;
  logic [AW-1:0]               lo_addr, hi_addr;
  logic [7:0]                  rd_lo, rd_hi;
  logic                        lo_ok, hi_ok;
  logic                        out_valid, out_valid_next;
  logic                        load;
  logic                        is_last;

  // Byte positions of the current channel word
  assign lo_pos  = {ch, 1'b1};
  assign hi_pos  = lo_pos + isfr_pkg::POS_W'(1);
  assign lo_in   = 8'(lo_pos) < MAX_B;
  assign hi_in   = 8'(hi_pos) < MAX_B;
  assign lo_addr = AW'(lo_pos);
  assign hi_addr = AW'(hi_pos);
  assign is_last = (ch == LAST_CH);

  // Frame store: written by the parser, read here at two addresses
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == isfr_pkg::BK_READ) begin
      rd_lo <= mem[lo_addr];
      rd_hi <= mem[hi_addr];
    end
  end

  // Entry valid bits make the store read as zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
      lo_ok     <= 1'b0;
      hi_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        store_vld[wr_addr] <= 1'b1;
      end
      if (state == isfr_pkg::BK_READ) begin
        lo_ok <= lo_in && store_vld[lo_addr];
        hi_ok <= hi_in && store_vld[hi_addr];
      end
    end
  end

  // Sequencer next state and handshake
  always_comb begin
    state_next     = state;
    ch_next        = ch;
    job_count_next = job_count;
    job_take       = 1'b0;
    load           = 1'b0;
    out_valid_next = out_valid && !pop;
    case (state)
      isfr_pkg::BK_IDLE: begin
        if (job.valid) begin
          job_take       = 1'b1;
          job_count_next = job.frame_count;
          ch_next        = '0;
          state_next     = isfr_pkg::BK_READ;
        end
      end
      isfr_pkg::BK_READ: begin
        state_next = isfr_pkg::BK_EMIT;
      end
      isfr_pkg::BK_EMIT: begin
        if (!out_valid || pop) begin
          load           = 1'b1;
          out_valid_next = 1'b1;
          ch_next        = ch + isfr_pkg::CHAN_W'(1);
          state_next     = is_last ? isfr_pkg::BK_IDLE : isfr_pkg::BK_READ;
        end
      end
      default: begin
        state_next = isfr_pkg::BK_IDLE;
      end
    endcase
  end

  assign busy  = (state != isfr_pkg::BK_IDLE);
  assign empty = !out_valid;

  // Sequencer and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isfr_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Channel counter, frame count and output word
  always_ff @(posedge clk) begin
    ch        <= ch_next;
    job_count <= job_count_next;
    if (load) begin
      channel_index <= ch;
      channel_value <= {hi_ok ? rd_hi : 8'd0, lo_ok ? rd_lo : 8'd0};
      frame_count   <= job_count;
      last_channel  <= is_last;
    end
  end

endmodule

[design/ibus_servo_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// ibus_servo_frame_receiver_top
// Servo frame receiver: parser front, frame store and channel word back end,
// and the gap setting register on an APB-style port.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while no servo frame is pending or being read out.
// After a good servo frame's last checksum byte the job is registered and taken by the
// idle back end, which then makes each word by a store read and an output load; full
// stays high until the last word is loaded, longer while a waiting word is not popped.
// Reset (rst, synchronous) clears the parser, counter, output valid flag and
// the store valid bits at once, so the store reads zero with no clearing pass.
module ibus_servo_frame_receiver_top #(
  parameter int MAX_FRAME_BYTES = 32,
  parameter int CHANNEL_COUNT   = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  data_byte,
  input  logic [7:0]                  elapsed_ms,
  output logic                        empty,
  input  logic                        pop,
  output logic [isfr_pkg::CHAN_W-1:0] channel_index,
  output logic [15:0]                 channel_value,
  output logic [7:0]                  frame_count,
  output logic                        last_channel,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int AW = $clog2(MAX_FRAME_BYTES);

  logic           [7:0] gap_ms;
  logic                 cfg_write;
  isfr_pkg::job_t       job;
  logic                 job_take;
  logic                 back_busy;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms <= isfr_pkg::GAP_RESET;
    end else if (cfg_write && (paddr[2] == isfr_pkg::REG_GAP)) begin
      gap_ms <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == isfr_pkg::REG_GAP) ? {24'd0, gap_ms} : 32'd0;

  // Parser front
  isfr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .PW(PW),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .elapsed_ms(elapsed_ms),
    .gap_ms(gap_ms),
    .back_busy(back_busy),
    .job(job),
    .job_take(job_take),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Store and channel word back end
  isfr_back #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job(job),
    .job_take(job_take),
    .busy(back_busy),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .empty(empty),
    .pop(pop),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .frame_count(frame_count),
    .last_channel(last_channel)
  );

  // The store is never written while the back end reads it
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !back_busy)
    else $error("frame store written while channel words are read");

  // The final word of a frame carries the highest channel number
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_channel) |-> (channel_index == isfr_pkg::CHAN_W'(CHANNEL_COUNT - 1)))
    else $error("last channel flag on wrong channel");

  // A pending frame that is taken leaves the back end busy and the job slot empty
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    job_take |=> (back_busy && !job.valid))
    else $error("frame hand-over lost");

endmodule

[tb/sv/ibus_servo_frame_receiver_top_tb.sv]
// ----------------------------------------------------------------------------
// ibus_servo_frame_receiver_top_tb
// Self-checking bench for the servo frame receiver. Serial bytes with their
// inter-byte silence are pushed into the block, and every channel word that
// comes out is compared with a cycle-free prediction of the frame parser.
// The gap setting is changed between phases, including both extremes.
// ----------------------------------------------------------------------------
module ibus_servo_frame_receiver_top_tb;

  localparam int FRAME_MAX   = 32;
  localparam int CHANNELS    = 14;
  localparam int RX_HOLD     = 400;
  localparam int DRAIN_SLACK = 40;
  localparam logic [2:0] GAP_ADDR = {isfr_pkg::REG_GAP, 2'b00};

  // One expected channel word
  typedef struct packed {
    logic [isfr_pkg::CHAN_W-1:0] chan;
    logic [15:0]                 value;
    logic [7:0]                  count;
    logic                        is_last;
  } chan_word_t;

  // Frame parser prediction and the channel words still owed by the block
  class servo_word_scoreboard;
    logic [7:0]        gap_setting;
    isfr_pkg::phase_t  phase;
    logic [7:0]        store_bytes [FRAME_MAX];
    logic [4:0]        fill;
    logic [4:0]        body_len;
    logic [15:0]       sum_left;
    logic [7:0]        sum_lo;
    logic [7:0]        servo_frames;
    chan_word_t        words_due [$];
    int                errors;

    function void clear();
      gap_setting = isfr_pkg::GAP_RESET;
      phase = isfr_pkg::PH_LENGTH;
      foreach (store_bytes[k]) store_bytes[k] = 8'd0;
      fill = '0;
      body_len = '0;
      sum_left = '0;
      sum_lo = '0;
      servo_frames = '0;
      words_due.delete();
      errors = 0;
    endfunction

    // Advance the parser by one accepted item and queue any channel words.
    function void take_byte(logic [7:0] b, logic [7:0] ms);
      chan_word_t w;
      int pos;
      // A long enough silence always restarts at the length byte.
      if (ms >= gap_setting) phase = isfr_pkg::PH_LENGTH;
      case (phase)
        isfr_pkg::PH_LENGTH: begin
          if (b <= FRAME_MAX && b > isfr_pkg::FRAME_OVERHEAD) begin
            fill = '0;
            body_len = 5'(b - isfr_pkg::FRAME_OVERHEAD);
            sum_left = isfr_pkg::SUM_INIT - b;
            phase = isfr_pkg::PH_DATA;
          end else begin
            phase = isfr_pkg::PH_DISCARD;
          end
        end
        isfr_pkg::PH_DATA: begin
          store_bytes[fill] = b;
          fill = fill + 5'd1;
          sum_left = sum_left - b;
          if (fill >= body_len) phase = isfr_pkg::PH_SUM_LO;
        end
        isfr_pkg::PH_SUM_LO: begin
          sum_lo = b;
          phase = isfr_pkg::PH_SUM_HI;
        end
        isfr_pkg::PH_SUM_HI: begin
          // Short servo frames pick up whatever earlier frames left behind.
          if ({b, sum_lo} == sum_left && store_bytes[0] == isfr_pkg::SERVO_COMMAND) begin
            servo_frames = servo_frames + 8'd1;
            for (int i = 0; i < CHANNELS; i++) begin
              pos = 2 * i + 1;
              w.chan = isfr_pkg::CHAN_W'(i);
              w.value[7:0] = (pos < FRAME_MAX) ? store_bytes[pos] : 8'd0;
              w.value[15:8] = (pos + 1 < FRAME_MAX) ? store_bytes[pos + 1] : 8'd0;
              w.count = servo_frames;
              w.is_last = (i == CHANNELS - 1);
              words_due.push_back(w);
            end
          end
          phase = isfr_pkg::PH_DISCARD;
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted channel word with the oldest expected one.
    function void check_word(logic [isfr_pkg::CHAN_W-1:0] idx, logic [15:0] val,
                             logic [7:0] cnt, logic last);
      chan_word_t w;
      if (words_due.size() == 0) begin
        $error("channel word %0d (value %h) arrived with none expected", idx, val);
        errors++;
      end else begin
        w = words_due.pop_front();
        if (idx !== w.chan) begin
          $error("channel_index: expected %0d, got %0d", w.chan, idx);
          errors++;
        end
        if (val !== w.value) begin
          $error("channel_value: expected %h, got %h", w.value, val);
          errors++;
        end
        if (cnt !== w.count) begin
          $error("frame_count: expected %0d, got %0d", w.count, cnt);
          errors++;
        end
        if (last !== w.is_last) begin
          $error("last_channel: expected %b, got %b", w.is_last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte = 8'd0;
  logic [7:0] elapsed_ms = 8'd0;
  logic empty;
  logic pop = 1'b0;
  logic [isfr_pkg::CHAN_W-1:0] channel_index;
  logic [15:0] channel_value;
  logic [7:0] frame_count;
  logic last_channel;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  servo_word_scoreboard words_sb;
  bit hold_rx = 1'b0;
  int items_sent = 0;

  ibus_servo_frame_receiver_top #(
    .MAX_FRAME_BYTES(FRAME_MAX),
    .CHANNEL_COUNT  (CHANNELS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .elapsed_ms   (elapsed_ms),
    .empty        (empty),
    .pop          (pop),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .frame_count  (frame_count),
    .last_channel (last_channel),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // Watch both handshakes at each rising edge.
  always @(posedge clk) begin
    if (!rst && push && !full) words_sb.take_byte(data_byte, elapsed_ms);
    if (!rst && pop && !empty)
      words_sb.check_word(channel_index, channel_value, frame_count, last_channel);
  end

  // Silence that starts a frame, and silence below the gap (any at gap 0).
  function automatic logic [7:0] silence_ms();
    return 8'($urandom_range(words_sb.gap_setting, 255));
  endfunction

  function automatic logic [7:0] burst_ms();
    if (words_sb.gap_setting == 8'd0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, words_sb.gap_setting - 1));
  endfunction

  // Append the two checksum bytes, optionally with one bit flipped.
  function automatic void seal_frame(ref logic [7:0] q[$], input bit spoil);
    logic [15:0] s;
    s = isfr_pkg::SUM_INIT;
    foreach (q[k]) s = s - q[k];
    if (spoil) s = s ^ (16'd1 << $urandom_range(0, 15));
    q.push_back(s[7:0]);
    q.push_back(s[15:8]);
  endfunction

  // Offer one item until it is taken, then maybe leave a gap.
  task automatic send_byte(input logic [7:0] b, input logic [7:0] ms);
    int r;
    int n;
    push <= 1'b1;
    data_byte <= b;
    elapsed_ms <= ms;
    do @(posedge clk); while (full);
    items_sent++;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(15, 80);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Send a byte sequence as a frame; a silence is forced at position cut too.
  task automatic send_seq(input logic [7:0] q[$], input int cut);
    for (int k = 0; k < q.size(); k++)
      send_byte(q[k], (k == 0 || k == cut) ? silence_ms() : burst_ms());
  endtask

  // Stop sending, let every expected word arrive, then let the block settle.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (words_sb.words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write the gap setting, then read it back.
  task automatic write_gap(input logic [7:0] ms);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GAP_ADDR;
    pwdata <= {24'd0, ms};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    words_sb.gap_setting = ms;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== ms) begin
      $error("gap_ms readback: expected %0d, got %0d", ms, prdata[7:0]);
      words_sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random pops, with one long hold-off on request.
  initial begin : rx_side
    int r;
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        pop <= 1'b0;
        n = RX_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          pop <= 1'b1;
          n = $urandom_range(1, 24);
        end else begin
          pop <= 1'b0;
          n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // Stimulus: directed frames, then random phases over several gap settings.
  initial begin : stimulus
    logic [7:0] q[$];
    logic [7:0] gap_plan [5];
    int budget [5];
    int goal;
    int r;
    int flen;
    int cut;
    words_sb = new;
    words_sb.clear();
    gap_plan = '{isfr_pkg::GAP_RESET, 8'd255, 8'd0, 8'd1, 8'($urandom_range(2, 254))};
    budget = '{85, 60, 25, 30, 80};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Shortest servo frame straight after reset: every channel reads zero.
    q = '{8'd4, isfr_pkg::SERVO_COMMAND};
    seal_frame(q, 1'b0);
    send_seq(q, -1);
    // Length bytes out of range, two at exactly the gap, then an ignored byte.
    send_byte(8'd0, 8'd255);
    send_byte(8'd3, isfr_pkg::GAP_RESET);
    send_byte(8'd33, 8'd4);
    send_byte(8'd255, isfr_pkg::GAP_RESET);
    send_byte(8'd4, isfr_pkg::GAP_RESET - 8'd1);
    // A good frame with another command leaves bytes in the store.
    q = '{8'd5, 8'h41, 8'hFF};
    seal_frame(q, 1'b0);
    send_seq(q, -1);
    // Short servo frame: one fresh channel, the rest still zero.
    q = '{8'd6, isfr_pkg::SERVO_COMMAND, 8'h34, 8'h12};
    seal_frame(q, 1'b0);
    send_seq(q, -1);
    // Servo frame with a broken checksum.
    q = '{8'd4, isfr_pkg::SERVO_COMMAND};
    seal_frame(q, 1'b1);
    send_seq(q, -1);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_gap(gap_plan[p]);
      if (p == 0) hold_rx = 1'b1;
      goal = items_sent + budget[p];
      while (items_sent < goal) begin
        r = $urandom_range(0, 99);
        if (r >= 88) begin
          // Noise between frames
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 8'($urandom));
        end else begin
          flen = ($urandom_range(0, 2) != 0) ? FRAME_MAX : $urandom_range(4, FRAME_MAX);
          q = '{8'(flen)};
          repeat (flen - 3) q.push_back(8'($urandom));
          cut = -1;
          if (r >= 60 && r < 70) begin
            while (q[1] == isfr_pkg::SERVO_COMMAND) q[1] = 8'($urandom);
          end else begin
            q[1] = isfr_pkg::SERVO_COMMAND;
          end
          seal_frame(q, r >= 70 && r < 78);
          if (r >= 78) cut = $urandom_range(1, q.size() - 1);
          send_seq(q, cut);
        end
      end
    end

    wait_drained();
    if (words_sb.errors == 0 && words_sb.words_due.size() == 0) begin
      $display("PASS ibus_servo_frame_receiver_top");
    end else begin
      $display("FAIL ibus_servo_frame_receiver_top");
    end
    $finish;
  end

  // Overall time limit
  initial begin : watchdog
    #30000000;
    $display("FAIL ibus_servo_frame_receiver_top");
    $finish;
  end

endmodule
